FILE: hdl/swb_pkg.sv
// Shared types, constants and the ranking function of the skin weight blend block.
package swb_pkg;

   localparam int TABLE_DEPTH_DEF = 8;
   localparam int KEEP_COUNT_DEF  = 4;
   localparam int BONE_W          = 8;
   localparam int SUM_W           = 32;
   localparam int Q_W             = 16;
   localparam logic [15:0] Q15_ONE = 16'd32768;

   typedef struct packed {
      logic              valid;
      logic [BONE_W-1:0] bone;
      logic [SUM_W-1:0]  sum;
   } cell_data_type;

   typedef struct packed {
      logic              en;
      logic [BONE_W-1:0] bone;
      logic [SUM_W-1:0]  add;
   } merge_cmd_type;

   // True when a ranks strictly above b: valid first, larger sum, then lower bone.
   function automatic logic ranks_above(input cell_data_type a, input cell_data_type b);
      logic r;
      if (!a.valid) begin
         r = 1'b0;
      end else if (!b.valid) begin
         r = 1'b1;
      end else if (a.sum != b.sum) begin
         r = (a.sum > b.sum);
      end else begin
         r = (a.bone < b.bone);
      end
      return r;
   endfunction

endpackage

FILE: hdl/skin_weight_blend_top4.sv
// Top level of the skin weight blend block: cell row, sorter control and divider.
//
// Input entries arrive on the req_ channel, one (side, bone, weight) entry per
// transfer, each carrying the blend factor; req_last_entry closes a blend.
// For each entry the scaled weight is registered, then broadcast to the row
// of cells, which merge it by parallel bone compare.
// After the last entry the row sorts itself by odd-even transposition, the
// kept sums are totalled one at a time, and each kept weight is normalised
// by a restoring divider, with a load step before it and an output step
// after it. An empty blend gives one result.
// Results appear on the rsp_ channel from an output register, one per
// transfer, with rsp_last_result on the final one. When the receiver stalls
// the divider waits with its result until the register is free; a new blend
// may start as soon as the final result sits in the output register.
// Reset empties the table, clears the overflow flag and drops rsp_valid.
module skin_weight_blend_top4 #(
   parameter int TABLE_DEPTH = swb_pkg::TABLE_DEPTH_DEF,
   parameter int KEEP_COUNT  = swb_pkg::KEEP_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_side,
   input  logic signed [8:0] req_bone,
   input  logic [15:0] req_weight,
   input  logic [15:0] req_blend_factor,
   input  logic        req_last_entry,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_bone,
   output logic [15:0] rsp_out_weight,
   output logic        rsp_empty_res,
   output logic        rsp_overflow,
   output logic        rsp_last_result
);
   import swb_pkg::*;

   localparam int KEEP_EFF = (KEEP_COUNT < TABLE_DEPTH) ? KEEP_COUNT : TABLE_DEPTH;
   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_W    = SUM_W + $clog2(KEEP_EFF);
   localparam int STEP_W   = $clog2(Q_W);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MERGE, ST_SORT, ST_TOTAL, ST_LOAD, ST_DIV, ST_EMIT
   } state_type;

   state_type         state_ff;
   logic              m_en_ff;
   logic [BONE_W-1:0] m_bone_ff;
   logic [SUM_W-1:0]  m_add_ff;
   logic              m_last_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              drop_ff;
   logic [IDX_W-1:0]  ph_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [TOT_W-1:0]  rem_ff;
   logic [Q_W-1:0]    q_ff;
   logic [STEP_W-1:0] step_ff;
   logic              empty_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_bone_ff;
   logic [15:0]       rsp_weight_ff;
   logic              rsp_empty_ff;
   logic              rsp_ovf_ff;
   logic              rsp_last_ff;

   cell_data_type     cell_q [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic              any_hit;
   merge_cmd_type     merge_cmd;
   logic              clear_cells;
   logic              sort_en;

   logic [15:0]       f_clamp;
   logic [15:0]       scale;
   logic [SUM_W-1:0]  prod;
   logic [CNT_W-1:0]  keep;
   cell_data_type     sel;
   logic [TOT_W-1:0]  total_in;
   logic [TOT_W:0]    trial;
   logic              k_last;

   assign f_clamp = (req_blend_factor > Q15_ONE) ? Q15_ONE : req_blend_factor;
   assign scale   = req_side ? f_clamp : (Q15_ONE - f_clamp);
   assign prod    = SUM_W'(req_weight) * SUM_W'(scale);

   assign req_ready = (state_ff == ST_IDLE);
   assign any_hit   = |hit_vec;
   assign sort_en   = (state_ff == ST_SORT);
   assign clear_cells = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready) && k_last;

   assign merge_cmd.en   = (state_ff == ST_MERGE) && m_en_ff;
   assign merge_cmd.bone = m_bone_ff;
   assign merge_cmd.add  = m_add_ff;

   assign keep     = (count_ff < CNT_W'(KEEP_EFF)) ? count_ff : CNT_W'(KEEP_EFF);
   assign sel      = cell_q[k_ff];
   assign total_in = total_ff + TOT_W'(sel.sum);
   assign trial    = {rem_ff, (step_ff == '0) ? sel.sum[0] : 1'b0};
   assign k_last   = empty_ff || ((CNT_W'(k_ff) + CNT_W'(1)) == keep);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic          is_left;
      logic          partner_ok;
      cell_data_type partner;
      logic          prev_valid;

      // Even phases pair cells from an even index, odd phases from an odd one.
      assign is_left = (ph_ff[0] == 1'(i % 2));
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = cell_q[i-1].valid;
      end
      if (i == 0) begin : g_p0
         assign partner    = cell_q[i+1];
         assign partner_ok = is_left;
      end else if (i == TABLE_DEPTH - 1) begin : g_pn
         assign partner    = cell_q[i-1];
         assign partner_ok = !is_left;
      end else begin : g_pm
         assign partner    = is_left ? cell_q[i+1] : cell_q[i-1];
         assign partner_ok = 1'b1;
      end

      swb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear_cells),
         .merge      (merge_cmd),
         .any_hit    (any_hit),
         .prev_valid (prev_valid),
         .sort_en    (sort_en),
         .is_left    (is_left),
         .partner_ok (partner_ok),
         .partner    (partner),
         .data       (cell_q[i]),
         .hit        (hit_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         m_en_ff      <= 1'b0;
         ph_ff        <= '0;
         k_ff         <= '0;
         step_ff      <= '0;
         empty_ff     <= 1'b0;
      end else begin
         // In ST_EMIT a taken result is replaced by the next one below.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  m_en_ff   <= !req_bone[8] && (req_weight != '0);
                  m_bone_ff <= req_bone[7:0];
                  m_add_ff  <= prod;
                  m_last_ff <= req_last_entry;
                  state_ff  <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               if (m_en_ff && !any_hit) begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     drop_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end
               ph_ff    <= '0;
               state_ff <= m_last_ff ? ST_SORT : ST_IDLE;
            end
            ST_SORT: begin
               ph_ff <= ph_ff + IDX_W'(1);
               if (ph_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  k_ff     <= '0;
                  total_ff <= '0;
                  state_ff <= ST_TOTAL;
               end
            end
            ST_TOTAL: begin
               if (keep == '0) begin
                  empty_ff <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  total_ff <= total_in;
                  if ((CNT_W'(k_ff) + CNT_W'(1)) == keep) begin
                     k_ff <= '0;
                     if (total_in == '0) begin
                        empty_ff <= 1'b1;
                        state_ff <= ST_EMIT;
                     end else begin
                        empty_ff <= 1'b0;
                        state_ff <= ST_LOAD;
                     end
                  end else begin
                     k_ff <= k_ff + IDX_W'(1);
                  end
               end
            end
            ST_LOAD: begin
               // Quotient fits in 16 bits, so the first partial remainder is sum / 2.
               rem_ff   <= TOT_W'(sel.sum[SUM_W-1:1]);
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (trial >= {1'b0, total_ff}) begin
                  rem_ff <= TOT_W'(trial - {1'b0, total_ff});
                  q_ff   <= {q_ff[Q_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[TOT_W-1:0];
                  q_ff   <= {q_ff[Q_W-2:0], 1'b0};
               end
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(Q_W - 1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_bone_ff   <= empty_ff ? '0 : sel.bone;
                  rsp_weight_ff <= empty_ff ? '0 : q_ff;
                  rsp_empty_ff  <= empty_ff;
                  rsp_ovf_ff    <= drop_ff;
                  rsp_last_ff   <= k_last;
                  if (k_last) begin
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     empty_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + IDX_W'(1);
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_bone    = rsp_bone_ff;
   assign rsp_out_weight  = rsp_weight_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: hdl/swb_cell.sv
// One table cell: merges a broadcast entry and takes part in the odd-even sort.
module swb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  swb_pkg::merge_cmd_type merge,
   input  logic                   any_hit,
   input  logic                   prev_valid,
   input  logic                   sort_en,
   input  logic                   is_left,
   input  logic                   partner_ok,
   input  swb_pkg::cell_data_type partner,
   output swb_pkg::cell_data_type data,
   output logic                   hit
);
   import swb_pkg::*;

   cell_data_type data_ff;
   logic [SUM_W:0] sum_wide;
   logic           take_partner;
   logic           claim;

   assign data     = data_ff;
   assign hit      = data_ff.valid && (data_ff.bone == merge.bone);
   assign sum_wide = {1'b0, data_ff.sum} + {1'b0, merge.add};
   assign claim    = merge.en && !any_hit && !data_ff.valid && prev_valid;

   // The left cell of a pair keeps the higher ranked entry, the right cell the lower.
   assign take_partner = sort_en && partner_ok &&
                         (is_left ? ranks_above(partner, data_ff)
                                  : ranks_above(data_ff, partner));

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         data_ff.valid <= 1'b0;
      end else if (take_partner) begin
         data_ff <= partner;
      end else if (merge.en && hit) begin
         data_ff.sum <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      end else if (claim) begin
         data_ff.valid <= 1'b1;
         data_ff.bone  <= merge.bone;
         data_ff.sum   <= merge.add;
      end
   end

endmodule

FILE: hdl/swb_check.sv
// Port-level checks of the skin weight blend block, bound to its top level.
module swb_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_bone,
   input logic [15:0] rsp_out_weight,
   input logic        rsp_empty_res,
   input logic        rsp_last_result
);
   import swb_pkg::*;

   // A result that is not taken stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // An empty result carries no influence and closes the blend.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
         rsp_last_result && rsp_out_bone == '0 && rsp_out_weight == '0)
      else $error("malformed empty result");

   // A normalised weight never exceeds one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_weight <= Q15_ONE)
      else $error("normalised weight above one");

   // Nothing is offered straight after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind skin_weight_blend_top4 swb_check u_swb_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_bone    (rsp_out_bone),
   .rsp_out_weight  (rsp_out_weight),
   .rsp_empty_res   (rsp_empty_res),
   .rsp_last_result (rsp_last_result)
);
